// ===== rtl/sat_pkg.sv =====
// Shared types and constants for the shell argument tokeniser.
`default_nettype none
package sat_pkg;

    localparam int MAX_ARGS_DEF = 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_END_ARG  = 2'd1,
        KIND_END_LINE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } quote_t;

    // Results caused by one character, at most one of each sort, emitted in field order.
    typedef struct packed {
        logic       char_v;
        logic       end_v;
        logic       eol_v;
        logic [7:0] ch;
        logic [3:0] idx;
        logic [4:0] count;
    } bundle_t;

endpackage
`default_nettype wire

// ===== rtl/sat_step.sv =====
// Tokeniser state and per-character decode into a result bundle.
`default_nettype none
module sat_step #(
    parameter int MAX_ARGS = sat_pkg::MAX_ARGS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       ch,
    input  wire logic             eol,
    output sat_pkg::bundle_t      bundle
);
    import sat_pkg::*;

    localparam int CW = $clog2(MAX_ARGS + 1);
    localparam int EW = (CW > 5) ? CW : 5;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ARGS);

    logic          inside_reg, inside_next;
    quote_t        quote_reg, quote_next;
    logic          esc_reg, esc_next;
    logic [CW-1:0] args_reg, args_next;

    logic          blank, is_bs;
    quote_t        q;
    logic          in_arg, esc, emit_char, emit_end;
    quote_t        oq;
    logic [CW-1:0] args;
    logic [EW-1:0] idx_ext, cnt_ext;

    always_comb begin
        blank = (ch == CH_SPACE) || (ch == CH_TAB);
        is_bs = (ch == CH_BSLASH);
        q = (ch == CH_SQUOTE) ? QUOTE_SINGLE :
            (ch == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_NONE;

        in_arg    = inside_reg;
        oq        = quote_reg;
        esc       = esc_reg;
        args      = args_reg;
        emit_char = 1'b0;
        emit_end  = 1'b0;

        if (!inside_reg && (args_reg < MAX_C) && !blank) begin
            in_arg = 1'b1;
            oq     = QUOTE_NONE;
            esc    = 1'b0;
        end

        if (in_arg) begin
            priority if (esc) begin
                emit_char = 1'b1;
                esc       = 1'b0;
            end else if (oq == QUOTE_NONE && blank) begin
                emit_end = 1'b1;
                args     = args + CW'(1);
                in_arg   = 1'b0;
            end else if (is_bs && !eol) begin
                esc = 1'b1;
            end else if (q != QUOTE_NONE && oq == QUOTE_NONE) begin
                oq = q;
            end else if (q != QUOTE_NONE && oq == q) begin
                oq = QUOTE_NONE;
            end else begin
                emit_char = 1'b1;
            end
        end

        // an argument still open at the line's end is closed here
        if (eol && in_arg) begin
            emit_end = 1'b1;
            args     = args + CW'(1);
        end

        idx_ext = EW'(args_reg);
        cnt_ext = EW'(args);

        bundle.char_v = emit_char;
        bundle.end_v  = emit_end;
        bundle.eol_v  = eol;
        bundle.ch     = ch;
        bundle.idx    = idx_ext[3:0];
        bundle.count  = cnt_ext[4:0];

        if (eol) begin
            inside_next = 1'b0;
            quote_next  = QUOTE_NONE;
            esc_next    = 1'b0;
            args_next   = '0;
        end else begin
            inside_next = in_arg;
            quote_next  = oq;
            esc_next    = esc;
            args_next   = args;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            quote_reg  <= QUOTE_NONE;
            esc_reg    <= 1'b0;
            args_reg   <= '0;
        end else if (accept) begin
            inside_reg <= inside_next;
            quote_reg  <= quote_next;
            esc_reg    <= esc_next;
            args_reg   <= args_next;
        end
    end

    a_args_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        args_reg <= MAX_C) else $error("argument count beyond limit");
    a_esc_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> inside_reg) else $error("escape pending outside an argument");
    a_eol_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eol |=> !inside_reg && args_reg == '0 && quote_reg == QUOTE_NONE)
        else $error("state not cleared after end of line");

endmodule
`default_nettype wire

// ===== rtl/sat_out.sv =====
// Result register: holds one character's bundle and hands its results out one per cycle while the receiver is ready.
`default_nettype none
module sat_out (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sat_pkg::bundle_t  bundle,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [3:0]             m_arg_index,
    output logic [7:0]             m_out_char,
    output logic [4:0]             m_arg_count,
    output logic                   m_last_of_run
);
    import sat_pkg::*;

    // pending results: bit 0 character, bit 1 end of argument, bit 2 end of line
    logic [2:0] pend_reg, pend_next;
    logic [7:0] ch_reg;
    logic [3:0] idx_reg;
    logic [4:0] count_reg;

    logic [2:0] cur;
    logic       take, load;
    kind_t      kind;

    always_comb begin
        cur = pend_reg & (~pend_reg + 3'd1);   // lowest pending result
        m_valid = |pend_reg;
        m_last_of_run = (pend_reg == cur);
        take = m_valid && m_ready;
        in_ready = !m_valid || (take && m_last_of_run);
        load = in_valid && in_ready;

        priority if (cur[0]) begin
            kind = KIND_CHAR;
        end else if (cur[1]) begin
            kind = KIND_END_ARG;
        end else begin
            kind = KIND_END_LINE;
        end

        m_kind      = kind;
        m_arg_index = (kind == KIND_END_LINE) ? 4'd0 : idx_reg;
        m_out_char  = (kind == KIND_CHAR) ? ch_reg : 8'd0;
        m_arg_count = (kind == KIND_END_LINE) ? count_reg : 5'd0;

        if (load) begin
            pend_next = {bundle.eol_v, bundle.end_v, bundle.char_v};
        end else if (take) begin
            pend_next = pend_reg & ~cur;
        end else begin
            pend_next = pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ch_reg    <= bundle.ch;
            idx_reg   <= bundle.idx;
            count_reg <= bundle.count;
        end
    end

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !in_ready) else $error("input taken over a stalled result");
    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_END_LINE |-> m_last_of_run)
        else $error("end of line not final result");
    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_of_run |-> in_ready)
        else $error("slot not freed on final result");
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !m_last_of_run |=> m_valid) else $error("pending results lost");

endmodule
`default_nettype wire

// ===== rtl/shell_argument_tokenizer.sv =====
// Top level of the shell argument tokeniser.
// The first result of a character is presented in the cycle after its transaction.
// Throughput: one character per cycle while each gives at most one result and the receiver
// is ready; a character giving more than one result (up to 3, only at end of line) holds the
// input until its last result is taken, as all results leave through the single result register.
// Reset: synchronous, active low; clears the parser state and any pending results.
`default_nettype none
module shell_argument_tokenizer #(
    parameter int MAX_ARGS = sat_pkg::MAX_ARGS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_end_of_line,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [3:0]      m_arg_index,
    output logic [7:0]      m_out_char,
    output logic [4:0]      m_arg_count,
    output logic            m_last_of_run
);
    import sat_pkg::*;

    bundle_t bundle;
    logic    accept;

    assign accept = s_valid && s_ready;

    sat_step #(
        .MAX_ARGS (MAX_ARGS)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_ch),
        .eol     (s_end_of_line),
        .bundle  (bundle)
    );

    sat_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .bundle        (bundle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_arg_index   (m_arg_index),
        .m_out_char    (m_out_char),
        .m_arg_count   (m_arg_count),
        .m_last_of_run (m_last_of_run)
    );

endmodule
`default_nettype wire

// ===== tb/sat_token_checker.sv =====
// Checker for the shell argument tokeniser: predicts results from input transactions and compares.
`default_nettype none
module sat_token_checker #(
    parameter int MAX_ARGS = sat_pkg::MAX_ARGS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_end_of_line,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [1:0] m_kind,
    input  wire logic [3:0] m_arg_index,
    input  wire logic [7:0] m_out_char,
    input  wire logic [4:0] m_arg_count,
    input  wire logic       m_last_of_run,
    output int              mismatches,
    output int              pending_tokens,
    output int              tokens_checked,
    output int              lines_at_limit
);
    import sat_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] idx;
        logic [7:0] ch;
        logic [4:0] count;
        logic       last;
    } token_t;

    token_t expected_tokens[$];

    // parser state as seen from outside
    logic   in_arg;
    quote_t open_q;
    logic   escaped;
    int     args_done;

    token_t run_buf[3];
    int     run_len;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void add_token(input kind_t k, input int idx, input logic [7:0] c,
                                      input int cnt);
        token_t t;
        t.kind  = k;
        t.idx   = idx[3:0];
        t.ch    = c;
        t.count = cnt[4:0];
        t.last  = 1'b0;
        run_buf[run_len] = t;
        run_len++;
    endfunction

    function automatic void tokenize_char(input logic [7:0] c, input logic eol);
        logic   blank;
        quote_t q;
        token_t t;
        blank   = (c == CH_SPACE) || (c == CH_TAB);
        run_len = 0;
        if (!in_arg && args_done < MAX_ARGS && !blank) begin
            in_arg  = 1'b1;
            open_q  = QUOTE_NONE;
            escaped = 1'b0;
        end
        if (in_arg) begin
            q = (c == CH_SQUOTE) ? QUOTE_SINGLE : (c == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_NONE;
            if (escaped) begin
                add_token(KIND_CHAR, args_done, c, 0);
                escaped = 1'b0;
            end else if (open_q == QUOTE_NONE && blank) begin
                add_token(KIND_END_ARG, args_done, 8'h00, 0);
                args_done++;
                in_arg = 1'b0;
            end else if (c == CH_BSLASH && !eol) begin
                escaped = 1'b1;
            end else if (q != QUOTE_NONE && open_q == QUOTE_NONE) begin
                open_q = q;
            end else if (q != QUOTE_NONE && open_q == q) begin
                open_q = QUOTE_NONE;
            end else begin
                add_token(KIND_CHAR, args_done, c, 0);
            end
        end
        if (eol) begin
            if (in_arg) begin
                add_token(KIND_END_ARG, args_done, 8'h00, 0);
                args_done++;
            end
            if (args_done >= MAX_ARGS)
                lines_at_limit++;
            add_token(KIND_END_LINE, 0, 8'h00, args_done);
            in_arg    = 1'b0;
            open_q    = QUOTE_NONE;
            escaped   = 1'b0;
            args_done = 0;
        end
        if (run_len > 0) begin
            t = run_buf[run_len - 1];
            t.last = 1'b1;
            run_buf[run_len - 1] = t;
        end
        for (int i = 0; i < run_len; i++)
            expected_tokens.push_back(run_buf[i]);
    endfunction

    always @(posedge aclk) begin : watch
        token_t want;
        if (!aresetn) begin
            expected_tokens.delete();
            in_arg         = 1'b0;
            open_q         = QUOTE_NONE;
            escaped        = 1'b0;
            args_done      = 0;
            mismatches     = 0;
            tokens_checked = 0;
            lines_at_limit = 0;
        end else begin
            // results come no earlier than the cycle after their character, so compare first
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("result with nothing pending, kind", m_kind, 0);
                end else begin
                    want = expected_tokens.pop_front();
                    tokens_checked++;
                    if (m_kind !== want.kind)
                        report_mismatch("kind", m_kind, want.kind);
                    if (m_arg_index !== want.idx)
                        report_mismatch("arg_index", m_arg_index, want.idx);
                    if (m_out_char !== want.ch)
                        report_mismatch("out_char", m_out_char, want.ch);
                    if (m_arg_count !== want.count)
                        report_mismatch("arg_count", m_arg_count, want.count);
                    if (m_last_of_run !== want.last)
                        report_mismatch("last_of_run", m_last_of_run, want.last);
                end
            end
            if (s_valid && s_ready)
                tokenize_char(s_ch, s_end_of_line);
        end
        pending_tokens = expected_tokens.size();
    end

endmodule
`default_nettype wire

// ===== tb/tb_shell_argument_tokenizer.sv =====
// Top of the shell argument tokeniser testbench: clock, reset, line stimulus and verdict.
`default_nettype none
module tb_shell_argument_tokenizer;
    import sat_pkg::*;

    localparam int MAX_ARGS     = MAX_ARGS_DEF;
    localparam int CHAR_TARGET  = 350;
    localparam int CALM_FROM    = 290;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 1000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_ch;
    logic       s_end_of_line;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [3:0] m_arg_index;
    logic [7:0] m_out_char;
    logic [4:0] m_arg_count;
    logic       m_last_of_run;

    int mismatches;
    int pending_tokens;
    int tokens_checked;
    int lines_at_limit;

    logic gaps_on;
    logic calm;
    logic hold_req;
    logic hold_done;
    int   chars_sent;
    int   lines_sent;
    int   idle_cycles;

    logic [7:0] line_buf[$];

    shell_argument_tokenizer #(
        .MAX_ARGS(MAX_ARGS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_of_line (s_end_of_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_arg_index   (m_arg_index),
        .m_out_char    (m_out_char),
        .m_arg_count   (m_arg_count),
        .m_last_of_run (m_last_of_run)
    );

    sat_token_checker #(
        .MAX_ARGS(MAX_ARGS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_end_of_line  (s_end_of_line),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_arg_index    (m_arg_index),
        .m_out_char     (m_out_char),
        .m_arg_count    (m_arg_count),
        .m_last_of_run  (m_last_of_run),
        .mismatches     (mismatches),
        .pending_tokens (pending_tokens),
        .tokens_checked (tokens_checked),
        .lines_at_limit (lines_at_limit)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // ends the run if nothing moves on either channel for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("stalled for %0d cycles with %0d results pending", IDLE_LIMIT, pending_tokens);
        $display("tb_shell_argument_tokenizer NOT OK");
        $finish;
    end

    task automatic put_char(input logic [7:0] c, input logic eol);
        if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_ch          <= c;
        s_end_of_line <= eol;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++) begin
            put_char(line_buf[i], i == line_buf.size() - 1);
            chars_sent++;
        end
        line_buf.delete();
        lines_sent++;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
               c == CH_BSLASH)
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] any_quote();
        return $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    endfunction

    function automatic void add_blanks(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            line_buf.push_back($urandom_range(0, 2) ? CH_SPACE : CH_TAB);
    endfunction

    // one argument built from plain runs, escapes and quoted spans
    function automatic void add_word();
        int         segs;
        int         span;
        logic [7:0] q;
        segs = $urandom_range(1, 4);
        for (int k = 0; k < segs; k++) begin
            case ($urandom_range(0, 5))
                0, 1, 2: line_buf.push_back(plain_char());
                3: begin
                    line_buf.push_back(CH_BSLASH);
                    line_buf.push_back(8'($urandom_range(1, 255)));
                end
                4: begin
                    q    = any_quote();
                    span = $urandom_range(0, 5);
                    line_buf.push_back(q);
                    for (int j = 0; j < span; j++) begin
                        case ($urandom_range(0, 6))
                            0: line_buf.push_back(CH_SPACE);
                            1: line_buf.push_back(CH_TAB);
                            2: line_buf.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
                            3: begin
                                line_buf.push_back(CH_BSLASH);
                                line_buf.push_back(8'($urandom_range(1, 255)));
                            end
                            default: line_buf.push_back(plain_char());
                        endcase
                    end
                    line_buf.push_back(q);
                end
                default: begin
                    q = any_quote();
                    line_buf.push_back(q);
                    line_buf.push_back(q);
                end
            endcase
        end
    endfunction

    function automatic void add_many_args(input int n);
        for (int i = 0; i < n; i++) begin
            line_buf.push_back(plain_char());
            line_buf.push_back(CH_SPACE);
        end
        line_buf.push_back(plain_char());
    endfunction

    function automatic void add_plain_line();
        int n;
        n = $urandom_range(1, 5);
        add_blanks(0, 2);
        for (int i = 0; i < n; i++) begin
            add_word();
            if (i < n - 1)
                add_blanks(1, 3);
        end
        if ($urandom_range(0, 3) == 0)
            add_blanks(1, 2);
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_ch          = 8'h00;
        s_end_of_line = 1'b0;
        gaps_on       = 1'b1;
        calm          = 1'b0;
        hold_req      = 1'b0;
        chars_sent    = 0;
        lines_sent    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed lines
        add_text("a");
        send_line();
        add_text(" \t");
        send_line();
        add_text("''");
        send_line();
        // other quote kept, escaped blank, backslash at end of line kept
        add_text("\"x'\"\\ b\\");
        send_line();
        add_text("'a\t");
        send_line();
        line_buf.push_back(8'h00);
        line_buf.push_back(CH_SPACE);
        line_buf.push_back(8'hFF);
        send_line();
        add_text("q ");
        send_line();
        add_text("\\\\");
        send_line();

        // random lines
        while (chars_sent < CHAR_TARGET) begin
            if (chars_sent >= CALM_FROM)
                calm = 1'b1;
            if (lines_sent == 8) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_tokens != 0) @(posedge aclk);
            end
            if (lines_sent == 8) begin
                // long receiver stall with back-to-back characters past the argument limit
                hold_req = 1'b1;
                gaps_on  = 1'b0;
                add_many_args(MAX_ARGS + 2);
                send_line();
                gaps_on  = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: add_plain_line();
                    6: add_many_args($urandom_range(MAX_ARGS - 2, MAX_ARGS + 2));
                    7: begin
                        add_plain_line();
                        add_blanks(1, 2);
                        if ($urandom_range(0, 1)) begin
                            line_buf.push_back(any_quote());
                            add_word();
                        end else begin
                            line_buf.push_back(CH_BSLASH);
                        end
                    end
                    default: begin
                        repeat ($urandom_range(1, 10)) begin
                            case ($urandom_range(0, 5))
                                0: line_buf.push_back(CH_SPACE);
                                1: line_buf.push_back(CH_BSLASH);
                                2: line_buf.push_back(any_quote());
                                default: line_buf.push_back(8'($urandom_range(1, 255)));
                            endcase
                        end
                    end
                endcase
                send_line();
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_tokens != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d characters in %0d lines; %0d results compared.",
                 chars_sent, lines_sent, tokens_checked);
        $display("%0d lines reached the argument limit; %0d mismatches.",
                 lines_at_limit, mismatches);
        if (mismatches == 0 && pending_tokens == 0) begin
            $display("tb_shell_argument_tokenizer OK");
        end else begin
            $display("tb_shell_argument_tokenizer NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
